FILE: rtl/sfd_pkg.sv
`default_nettype none
package sfd_pkg;

  localparam int unsigned SampleW = 24;
  localparam int unsigned OutW    = 26;
  localparam int unsigned HistW   = 26;
  localparam int unsigned DelayW  = 25;
  localparam int unsigned StepW   = 26;
  localparam int unsigned GainW   = 16;
  localparam int unsigned MixW    = 17;
  localparam int unsigned LenW    = 16;
  localparam int unsigned MulAW   = 27;
  localparam int unsigned MulBW   = 18;
  localparam int unsigned ProdW   = MulAW + MulBW;
  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 32;

  localparam logic [DelayW-1:0] DelayReset = 25'd3072000;
  localparam logic [GainW-1:0]  GainReset  = 16'd26214;
  localparam logic [MixW-1:0]   WetReset   = 17'd32768;
  localparam logic [LenW-1:0]   LenReset   = 16'd2400;
  localparam logic [GainW-1:0]  GainMax    = 16'd62259;
  localparam logic [MixW-1:0]   WetOne     = 17'd65536;
  localparam logic [4:0]        DivLast    = 5'd24;

  typedef enum logic [2:0] {
    REG_TARGET = 3'd0,
    REG_GAIN   = 3'd1,
    REG_WET    = 3'd2,
    REG_LEN    = 3'd3,
    REG_BYPASS = 3'd4,
    REG_STEREO = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_FRAC,
    MUL_FB,
    MUL_DRY,
    MUL_WET
  } mul_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADV,
    ST_ADDR,
    ST_RD1,
    ST_RD2,
    ST_MUL1,
    ST_DLY,
    ST_MUL2,
    ST_WR,
    ST_MUL4,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic    adv;
    logic    addr;
    logic    rd;
    logic    rd_hi;
    logic    dly;
    logic    wr;
    logic    acc;
    logic    fin;
    mul_op_e mul;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic busy;
    logic bypass;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

FILE: rtl/sfd_ctrl.sv
`default_nettype none
module sfd_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire sfd_pkg::status_t status_i,
  output logic                 in_stall_o,
  output sfd_pkg::cmd_t        cmd_o
);
  import sfd_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (status_i.in_valid && !status_i.busy) begin
          state_d = status_i.bypass ? ST_DONE : ST_ADV;
        end
      end
      ST_ADV:  state_d = ST_ADDR;
      ST_ADDR: state_d = ST_RD1;
      ST_RD1:  state_d = ST_RD2;
      ST_RD2:  state_d = ST_MUL1;
      ST_MUL1: state_d = ST_DLY;
      ST_DLY:  state_d = ST_MUL2;
      ST_MUL2: state_d = ST_WR;
      ST_WR:   state_d = ST_MUL4;
      ST_MUL4: state_d = ST_DONE;
      ST_DONE: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.mul  = MUL_NONE;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: in_stall_o = status_i.busy;
      ST_ADV:  cmd_o.adv = 1'b1;
      ST_ADDR: cmd_o.addr = 1'b1;
      ST_RD1:  cmd_o.rd = 1'b1;
      ST_RD2: begin
        cmd_o.rd    = 1'b1;
        cmd_o.rd_hi = 1'b1;
      end
      ST_MUL1: cmd_o.mul = MUL_FRAC;
      ST_DLY:  cmd_o.dly = 1'b1;
      ST_MUL2: cmd_o.mul = MUL_FB;
      ST_WR: begin
        cmd_o.wr  = 1'b1;
        cmd_o.mul = MUL_DRY;
      end
      ST_MUL4: begin
        cmd_o.acc = 1'b1;
        cmd_o.mul = MUL_WET;
      end
      ST_DONE: cmd_o.fin = 1'b1;
      default: in_stall_o = 1'b1;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/sfd_lane.sv
`default_nettype none
module sfd_lane #(
  parameter int unsigned DEPTH = 131072,
  parameter int unsigned FRACTION_BITS = 8,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire sfd_pkg::cmd_t                     cmd_i,
  input  wire logic                              active_i,
  input  wire logic signed [sfd_pkg::SampleW-1:0] sample_i,
  input  wire logic [sfd_pkg::GainW-1:0]         gain_i,
  input  wire logic [sfd_pkg::MixW-1:0]          wet_i,
  input  wire logic [sfd_pkg::MixW-1:0]          dry_i,
  input  wire logic [sfd_pkg::DelayW-1:0]        target_i,
  input  wire logic [sfd_pkg::DelayW-1:0]        start_target_i,
  input  wire logic [sfd_pkg::LenW-1:0]          ramp_len_i,
  input  wire logic                              ramp_start_i,
  input  wire logic [AW-1:0]                     wp_i,
  input  wire logic                              clr_we_i,
  input  wire logic [AW-1:0]                     clr_addr_i,
  output logic                                   div_busy_o,
  output logic signed [sfd_pkg::OutW-1:0]        result_o
);
  import sfd_pkg::*;

  localparam int unsigned FW = (FRACTION_BITS == 0) ? 1 : FRACTION_BITS;
  localparam int unsigned CW = ((DelayW > AW + FRACTION_BITS) ? DelayW
                                : AW + FRACTION_BITS) + 1;
  localparam logic [CW-1:0] LoVal    = CW'(1) << FRACTION_BITS;
  localparam logic [CW-1:0] HiVal    = CW'(DEPTH - 2) << FRACTION_BITS;
  localparam logic [CW-1:0] FracMask = (CW'(1) << FRACTION_BITS) - CW'(1);
  localparam logic [AW:0]   DepthW   = (AW+1)'(DEPTH);
  localparam logic [AW-1:0] LastAddr = AW'(DEPTH - 1);

  // ramp state and divider
  logic [DelayW-1:0]       cur_q;
  logic signed [StepW-1:0] step_q;
  logic [LenW-1:0]         cnt_q;
  logic                    busy_q;
  logic [4:0]              iter_q;
  logic [LenW-1:0]         rem_q;
  logic [DelayW-1:0]       quo_q;
  logic [LenW-1:0]         dvs_q;
  logic                    neg_q;

  logic signed [StepW-1:0] diff;
  logic [DelayW-1:0]       mag;
  logic [LenW:0]           rem_sh;
  logic                    ge;
  logic [LenW-1:0]         rem_n;
  logic [DelayW-1:0]       quo_n;
  logic signed [StepW-1:0] quo_s;
  logic signed [StepW-1:0] cur_sum;

  // new target comes straight from the write data
  assign diff    = $signed({1'b0, start_target_i}) - $signed({1'b0, cur_q});
  assign mag     = diff[StepW-1] ? DelayW'(-diff) : DelayW'(diff);
  assign rem_sh  = {rem_q, quo_q[DelayW-1]};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign rem_n   = ge ? LenW'(rem_sh - {1'b0, dvs_q}) : LenW'(rem_sh);
  assign quo_n   = {quo_q[DelayW-2:0], ge};
  assign quo_s   = $signed({1'b0, quo_n});
  assign cur_sum = $signed({1'b0, cur_q}) + step_q;
  assign div_busy_o = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= DelayReset;
      step_q <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      iter_q <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
      neg_q  <= 1'b0;
    end else if (ramp_start_i) begin
      if (ramp_len_i == '0) begin
        cur_q  <= start_target_i;
        cnt_q  <= '0;
        step_q <= '0;
        busy_q <= 1'b0;
      end else begin
        cnt_q  <= ramp_len_i;
        busy_q <= 1'b1;
        iter_q <= '0;
        rem_q  <= '0;
        quo_q  <= mag;
        dvs_q  <= ramp_len_i;
        neg_q  <= diff[StepW-1];
      end
    end else if (busy_q) begin
      rem_q  <= rem_n;
      quo_q  <= quo_n;
      iter_q <= iter_q + 5'd1;
      if (iter_q == DivLast) begin
        busy_q <= 1'b0;
        step_q <= neg_q ? -quo_s : quo_s;
      end
    end else if (cmd_i.adv && active_i) begin
      if (cnt_q == '0) begin
        cur_q <= target_i;
      end else begin
        cnt_q <= cnt_q - LenW'(1);
        if (cnt_q != LenW'(1)) begin
          cur_q <= DelayW'(cur_sum);
        end else begin
          cur_q <= target_i;
        end
      end
    end
  end

  // clamp and tap addresses
  logic [CW-1:0]  cur_ext, dl;
  logic [AW-1:0]  di, i1, i2;
  logic [AW:0]    wrap;
  logic [AW-1:0]  i1_q, i2_q;
  logic [FW-1:0]  fr_q;

  assign cur_ext = CW'(cur_q);
  assign dl   = (cur_ext < LoVal) ? LoVal : ((cur_ext > HiVal) ? HiVal : cur_ext);
  assign di   = AW'(dl >> FRACTION_BITS);
  assign wrap = {1'b0, wp_i} + DepthW - {1'b0, di};
  assign i1   = (wp_i >= di) ? (wp_i - di) : AW'(wrap);
  assign i2   = (i1 == '0) ? LastAddr : (i1 - AW'(1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.addr) begin
      i1_q <= i1;
      i2_q <= i2;
      fr_q <= FW'(dl & FracMask);
    end
  end

  // history memory
  logic [HistW-1:0]        mem [DEPTH];
  logic signed [HistW-1:0] rd_q, v1_q;
  logic signed [HistW-1:0] wval;

  always_ff @(posedge clk_i) begin
    if (clr_we_i) begin
      mem[clr_addr_i] <= '0;
    end else if (cmd_i.wr && active_i) begin
      mem[wp_i] <= wval;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_q <= $signed(mem[cmd_i.rd_hi ? i2_q : i1_q]);
    end
    if (cmd_i.rd && cmd_i.rd_hi) begin
      v1_q <= rd_q;
    end
  end

  // shared multiplier
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] prod_q, acc_q;
  logic signed [HistW-1:0] delayed_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.mul)
      MUL_FRAC: begin
        mul_a = MulAW'(rd_q) - MulAW'(v1_q);
        mul_b = $signed(MulBW'(fr_q));
      end
      MUL_FB: begin
        mul_a = MulAW'(delayed_q);
        mul_b = $signed({2'b00, gain_i});
      end
      MUL_DRY: begin
        mul_a = MulAW'(sample_i);
        mul_b = $signed({1'b0, dry_i});
      end
      MUL_WET: begin
        mul_a = MulAW'(delayed_q);
        mul_b = $signed({1'b0, wet_i});
      end
      MUL_NONE: begin
        mul_a = '0;
        mul_b = '0;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  logic signed [ProdW:0] dly_sum, fb_sum, out_sum;
  localparam logic signed [ProdW:0] ClipHi = (ProdW+1)'(16777216);
  localparam logic signed [ProdW:0] ClipLo = -ClipHi;

  assign dly_sum = (ProdW+1)'(v1_q) + (ProdW+1)'(prod_q >>> FRACTION_BITS);
  assign fb_sum  = (ProdW+1)'(sample_i) + (ProdW+1)'(prod_q >>> 16);
  assign wval    = (fb_sum > ClipHi) ? HistW'(ClipHi)
                 : ((fb_sum < ClipLo) ? HistW'(ClipLo) : HistW'(fb_sum));
  assign out_sum = (ProdW+1)'(acc_q) + (ProdW+1)'(prod_q);
  assign result_o = OutW'(out_sum >>> 16);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul != MUL_NONE) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd_i.dly) begin
      delayed_q <= HistW'(dly_sum);
    end
    if (cmd_i.acc) begin
      acc_q <= prod_q;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/stereo_feedback_delay.sv
`default_nettype none
// Stereo feedback delay (echo) with a ramped fractional delay time.
// Input channel: in_valid_i/in_stall_o with sample_left_i/sample_right_i
// (Q1.23). Output channel: out_valid_o/out_stall_i with out_left_o and
// out_right_o (Q3.23). One result transfer follows each input transfer.
// Registers are written and read over the APB-style port (byte address 4*i).
// A processed item runs through the step states from input transfer to output
// valid; in bypass it goes straight to the done state. One item at a time:
// the step sequence (two history reads, four passes through the per-channel
// multiplier) finishes before the next item is taken.
// After reset the two history memories are cleared, one entry per cycle over
// all DEPTH entries, with in_stall_o high; configuration writes are still taken.
// A delay_target write that changes the target starts a ramp; the step
// divider holds in_stall_o high while it runs.
// A finished result sits in the output register; while the receiver stalls,
// the next item is still taken and processed, then waits before the
// output register until it frees up.
module stereo_feedback_delay #(
  parameter int unsigned DEPTH = 131072,
  parameter int unsigned FRACTION_BITS = 8
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic signed [sfd_pkg::SampleW-1:0] sample_left_i,
  input  wire logic signed [sfd_pkg::SampleW-1:0] sample_right_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [sfd_pkg::OutW-1:0]        out_left_o,
  output logic signed [sfd_pkg::OutW-1:0]        out_right_o,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [sfd_pkg::AddrW-1:0]         paddr,
  input  wire logic [sfd_pkg::DataW-1:0]         pwdata,
  output logic [sfd_pkg::DataW-1:0]              prdata,
  output logic                                   pready
);
  import sfd_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LastAddr = AW'(DEPTH - 1);

  // configuration registers
  logic [DelayW-1:0] target_q;
  logic [GainW-1:0]  gain_q;
  logic [MixW-1:0]   wet_q;
  logic [LenW-1:0]   len_q;
  logic              bypass_q;
  logic              stereo_q;
  logic              cfg_wr;
  logic              ramp_start;
  reg_idx_e          reg_idx;

  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite;
  assign reg_idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign ramp_start = cfg_wr && (reg_idx == REG_TARGET)
                      && (pwdata[DelayW-1:0] != target_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= DelayReset;
      gain_q   <= GainReset;
      wet_q    <= WetReset;
      len_q    <= LenReset;
      bypass_q <= 1'b0;
      stereo_q <= 1'b1;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_TARGET: target_q <= pwdata[DelayW-1:0];
        REG_GAIN:   gain_q   <= pwdata[GainW-1:0];
        REG_WET:    wet_q    <= pwdata[MixW-1:0];
        REG_LEN:    len_q    <= pwdata[LenW-1:0];
        REG_BYPASS: bypass_q <= pwdata[0];
        REG_STEREO: stereo_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TARGET: prdata = DataW'(target_q);
      REG_GAIN:   prdata = DataW'(gain_q);
      REG_WET:    prdata = DataW'(wet_q);
      REG_LEN:    prdata = DataW'(len_q);
      REG_BYPASS: prdata = DataW'(bypass_q);
      REG_STEREO: prdata = DataW'(stereo_q);
      default:    prdata = '0;
    endcase
  end

  // out-of-range gain and wet values saturate
  logic [GainW-1:0] gain_eff;
  logic [MixW-1:0]  wet_eff, dry_eff;
  assign gain_eff = (gain_q > GainMax) ? GainMax : gain_q;
  assign wet_eff  = (wet_q > WetOne) ? WetOne : wet_q;
  assign dry_eff  = WetOne - wet_eff;

  // history clearing pass after reset
  logic          clearing_q;
  logic [AW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == LastAddr) begin
        clearing_q <= 1'b0;
      end
    end
  end

  // control
  cmd_t    cmd;
  status_t status;
  logic    div_busy_l, div_busy_r;
  logic    in_xfer, out_free, out_load;

  assign status.in_valid = in_valid_i;
  assign status.busy     = clearing_q || div_busy_l || div_busy_r;
  assign status.bypass   = bypass_q;
  assign status.out_free = out_free;

  sfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_o || !out_stall_i;
  assign out_load = cmd.fin && out_free;

  // captured input pair
  logic signed [SampleW-1:0] xl_q, xr_q;
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      xl_q <= sample_left_i;
      xr_q <= sample_right_i;
    end
  end

  // write pointer
  logic [AW-1:0] wp_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
    end else if (out_load && !bypass_q) begin
      wp_q <= (wp_q == LastAddr) ? '0 : wp_q + AW'(1);
    end
  end

  logic signed [OutW-1:0] res_l, res_r;

  sfd_lane #(
    .DEPTH         (DEPTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_lane_l (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .active_i       (1'b1),
    .sample_i       (xl_q),
    .gain_i         (gain_eff),
    .wet_i          (wet_eff),
    .dry_i          (dry_eff),
    .target_i       (target_q),
    .start_target_i (pwdata[DelayW-1:0]),
    .ramp_len_i     (len_q),
    .ramp_start_i   (ramp_start),
    .wp_i           (wp_q),
    .clr_we_i       (clearing_q),
    .clr_addr_i     (clr_addr_q),
    .div_busy_o     (div_busy_l),
    .result_o       (res_l)
  );

  // in mono mode the right lane neither advances its delay nor writes history
  sfd_lane #(
    .DEPTH         (DEPTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_lane_r (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .active_i       (stereo_q),
    .sample_i       (xr_q),
    .gain_i         (gain_eff),
    .wet_i          (wet_eff),
    .dry_i          (dry_eff),
    .target_i       (target_q),
    .start_target_i (pwdata[DelayW-1:0]),
    .ramp_len_i     (len_q),
    .ramp_start_i   (ramp_start),
    .wp_i           (wp_q),
    .clr_we_i       (clearing_q),
    .clr_addr_i     (clr_addr_q),
    .div_busy_o     (div_busy_r),
    .result_o       (res_r)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_load) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_left_o  <= bypass_q ? OutW'(xl_q) : res_l;
      out_right_o <= (bypass_q || !stereo_q) ? OutW'(xr_q) : res_r;
    end
  end

  // checks
  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> in_stall_o)
    else $error("input taken during history clearing");

  a_div_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_busy_l || div_busy_r) |-> in_stall_o)
    else $error("input taken while ramp step is computed");

  a_wp_holds_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(wp_q))
    else $error("write pointer moved while result was stalled");

endmodule
`default_nettype wire

FILE: bench/testbench.sv
// Stand-alone bench for stereo_feedback_delay.
// An initial block programs the registers over the APB-style port and fills
// a queue of sample pairs. A clocked driver offers them on the input
// channel. At each input transfer, the bench model predicts the echo output
// and queues it. A clocked monitor compares every output transfer with the
// oldest prediction.
module testbench;
  import sfd_pkg::*;

  localparam int unsigned DEPTH     = 131072;
  localparam int unsigned FRAC      = 8;
  localparam int unsigned UnusedIdx = 6;         // no register lives here
  localparam longint      ClipLim   = 64'sd16777216;
  localparam longint      TargetMax = 33554176;
  localparam int          CycleLimit = 1500000;  // clear pass + items, many times over
  localparam int          DrainWait  = 30;       // well past the latency of one item
  localparam int          LongHold   = 400;

  typedef struct {
    logic signed [SampleW-1:0] l;
    logic signed [SampleW-1:0] r;
  } pair_t;

  typedef struct {
    logic signed [OutW-1:0] l;
    logic signed [OutW-1:0] r;
  } echo_t;

  // DUT-facing signals; every input starts at a known value
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [SampleW-1:0] sample_left_i = '0;
  logic signed [SampleW-1:0] sample_right_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [OutW-1:0] out_left_o, out_right_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic pready;

  stereo_feedback_delay #(.DEPTH(DEPTH), .FRACTION_BITS(FRAC)) i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .sample_left_i, .sample_right_i,
    .out_valid_o, .out_stall_i, .out_left_o, .out_right_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Bench model of the echo: history, ramp state and register shadows.
  logic signed [HistW-1:0] hist_l [DEPTH];
  logic signed [HistW-1:0] hist_r [DEPTH];
  int unsigned wr_ptr = 0;
  longint cur_l, cur_r, step_l, step_r;
  int unsigned cnt_l, cnt_r;
  longint m_target, m_gain, m_wet, m_len;
  bit m_bypass, m_stereo;

  pair_t sample_queue[$];
  echo_t echo_expect[$];
  int mismatches = 0;
  int cycles = 0;
  int idle_mode = 0;   // 0 none, 1 sender idles, 2 receiver stalls, 3 both lightly
  int hold_req = 0;    // bump to ask the receiver for one long hold-off
  int hold_seen = 0;
  int hold_left = 0;

  // A target change starts a ramp on both channels, even in mono mode.
  function automatic void model_config(int idx, logic [DataW-1:0] val);
    case (idx)
      REG_TARGET: begin
        if (longint'(val[DelayW-1:0]) != m_target) begin
          m_target = val[DelayW-1:0];
          if (m_len == 0) begin
            cur_l = m_target; cur_r = m_target;
            cnt_l = 0; cnt_r = 0; step_l = 0; step_r = 0;
          end else begin
            cnt_l = m_len; cnt_r = m_len;
            step_l = (m_target - cur_l) / m_len;  // truncates toward zero
            step_r = (m_target - cur_r) / m_len;
          end
        end
      end
      REG_GAIN:   m_gain = val[GainW-1:0];
      REG_WET:    m_wet = val[MixW-1:0];
      REG_LEN:    m_len = val[LenW-1:0];
      REG_BYPASS: m_bypass = val[0];
      REG_STEREO: m_stereo = val[0];
      default: ;
    endcase
  endfunction

  // One ramp step: the last step lands exactly on the target.
  function automatic void step_delay(bit right);
    if (!right) begin
      if (cnt_l == 0) cur_l = m_target;
      else begin
        cnt_l--;
        if (cnt_l > 0) cur_l += step_l;
        else cur_l = m_target;
      end
    end else begin
      if (cnt_r == 0) cur_r = m_target;
      else begin
        cnt_r--;
        if (cnt_r > 0) cur_r += step_r;
        else cur_r = m_target;
      end
    end
  endfunction

  // Interpolated tap, feedback write into history, dry/wet mix.
  function automatic longint channel_out(bit right, longint x, longint dly);
    longint dl, fr, v1, v2, tap, fb, wet, w;
    int unsigned di, i1, i2;
    dl = dly;
    if (dl < (64'sd1 << FRAC)) dl = 64'sd1 << FRAC;
    if (dl > (longint'(DEPTH - 2) << FRAC)) dl = longint'(DEPTH - 2) << FRAC;
    di = dl >> FRAC;
    fr = dl & ((64'sd1 << FRAC) - 1);
    i1 = (wr_ptr + DEPTH - di) % DEPTH;
    i2 = (wr_ptr + 2 * DEPTH - di - 1) % DEPTH;
    v1 = right ? hist_r[i1] : hist_l[i1];
    v2 = right ? hist_r[i2] : hist_l[i2];
    tap = v1 + ((fr * (v2 - v1)) >>> FRAC);
    fb = (m_gain > GainMax) ? longint'(GainMax) : m_gain;
    wet = (m_wet > WetOne) ? longint'(WetOne) : m_wet;
    w = x + ((tap * fb) >>> 16);
    if (w > ClipLim) w = ClipLim;
    if (w < -ClipLim) w = -ClipLim;
    if (right) hist_r[wr_ptr] = w[HistW-1:0];
    else hist_l[wr_ptr] = w[HistW-1:0];
    return (x * (longint'(WetOne) - wet) + tap * wet) >>> 16;
  endfunction

  function automatic void predict_echo(logic signed [SampleW-1:0] sl,
                                       logic signed [SampleW-1:0] sr);
    longint xl, xr, yl, yr;
    echo_t e;
    xl = sl; xr = sr; yl = xl; yr = xr;
    if (!m_bypass) begin
      step_delay(1'b0);
      if (m_stereo) step_delay(1'b1);
      yl = channel_out(1'b0, xl, cur_l);
      if (m_stereo) yr = channel_out(1'b1, xr, cur_r);
      wr_ptr = (wr_ptr + 1) % DEPTH;
    end
    e.l = yl[OutW-1:0];
    e.r = yr[OutW-1:0];
    echo_expect.push_back(e);
  endfunction

  function automatic bit sender_idles();
    case (idle_mode)
      1: return $urandom_range(99) < 71;
      3: return $urandom_range(99) < 6;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_mode)
      2: return $urandom_range(99) < 71;
      3: return $urandom_range(99) < 6;
      default: return 1'b0;
    endcase
  endfunction

  // Driver: offers the head of the queue; a raised valid holds until transfer.
  always @(posedge clk_i or negedge rst_ni) begin : feeder
    logic offer;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      offer = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        predict_echo(sample_left_i, sample_right_i);
        sample_queue.delete(0);
        offer = 1'b0;
      end
      if (!offer && sample_queue.size() > 0 && !sender_idles()) begin
        in_valid_i <= 1'b1;
        sample_left_i <= sample_queue[0].l;
        sample_right_i <= sample_queue[0].r;
      end else begin
        in_valid_i <= offer;
      end
    end
  end

  // Receiver stall, with an optional long hold-off counted here.
  always @(posedge clk_i or negedge rst_ni) begin : sink_stall
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= receiver_stalls();
      end
    end
  end

  // Monitor: each output transfer against the oldest prediction.
  always @(posedge clk_i) begin : sink_check
    echo_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (echo_expect.size() == 0) begin
        $display("%0t: unexpected output transfer L=%0d R=%0d",
                 $time, out_left_o, out_right_o);
        mismatches++;
      end else begin
        e = echo_expect.pop_front();
        if (out_left_o !== e.l) begin
          $display("%0t: out_left expected %0d got %0d", $time, e.l, out_left_o);
          mismatches++;
        end
        if (out_right_o !== e.r) begin
          $display("%0t: out_right expected %0d got %0d", $time, e.r, out_right_o);
          mismatches++;
        end
      end
    end
  end

  // Timeout; the history clear pass after reset is covered by the limit.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic reg_write(input int idx, input logic [DataW-1:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= AddrW'(idx * 4); pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);  // access edge: register takes the write here
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    model_config(idx, val);
  endtask

  // Block is idle once queue and predictions are empty; then let it settle.
  task automatic wait_drained();
    while (sample_queue.size() != 0 || in_valid_i || echo_expect.size() != 0)
      @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic program_all(longint tgt, longint gain, longint wet, longint len,
                             bit byp, bit st);
    wait_drained();
    reg_write(REG_LEN, len);
    reg_write(REG_GAIN, gain);
    reg_write(REG_WET, wet);
    reg_write(REG_BYPASS, byp);
    reg_write(REG_STEREO, st);
    reg_write(REG_TARGET, tgt);
  endtask

  task automatic push_pair(logic signed [SampleW-1:0] l, logic signed [SampleW-1:0] r);
    pair_t p;
    p.l = l; p.r = r;
    sample_queue.push_back(p);
  endtask

  function automatic logic signed [SampleW-1:0] rand_sample();
    case ($urandom_range(7))
      0: return {1'b0, {(SampleW-1){1'b1}}};
      1: return {1'b1, {(SampleW-1){1'b0}}};
      default: return SampleW'($urandom);
    endcase
  endfunction

  function automatic longint rand_target();
    case ($urandom_range(15))
      0: return 0;
      1: return TargetMax;
      default: return $urandom_range(40 * 256, 256);
    endcase
  endfunction

  logic signed [SampleW-1:0] s_max = {1'b0, {(SampleW-1){1'b1}}};
  logic signed [SampleW-1:0] s_min = {1'b1, {(SampleW-1){1'b0}}};

  initial begin : stimulus
    int n;
    for (int i = 0; i < DEPTH; i++) begin
      hist_l[i] = '0;
      hist_r[i] = '0;
    end
    m_target = DelayReset; m_gain = GainReset; m_wet = WetReset; m_len = LenReset;
    m_bypass = 1'b0; m_stereo = 1'b1;
    cur_l = m_target; cur_r = m_target;
    step_l = 0; step_r = 0; cnt_l = 0; cnt_r = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: short delay with max gain drives the history into the clip
    program_all(256, GainMax, 32768, 0, 0, 1);
    reg_write(UnusedIdx, 32'hFFFF_FFFF);  // ignored index
    reg_write(UnusedIdx + 1, 32'h0);
    repeat (4) push_pair(s_max, s_min);
    push_pair(0, -1);
    // Out-of-range gain and wet act as their caps; fractional delay
    program_all(3 * 256 + 128, 65535, 131071, 0, 0, 1);
    push_pair(s_min, s_max); push_pair(-1, 0); push_pair(s_max, s_max);
    // Fully dry, then delay below one sample and at the top clamp
    program_all(0, 0, 0, 0, 0, 1);
    push_pair(s_max, s_min); push_pair(12345, -54321);
    program_all(TargetMax, 1000, 65536, 0, 0, 1);
    push_pair(s_min, s_min); push_pair(s_max, 7);
    // Bypass, then mono mode
    program_all(5 * 256, 40000, 20000, 0, 1, 1);
    push_pair(s_max, s_min); push_pair(-1, 1);
    program_all(2 * 256 + 17, 50000, 50000, 0, 0, 0);
    push_pair(s_max, s_min); push_pair(4, -4); push_pair(s_min, s_max);
    // Ramp toward a new target; same-value target write leaves the ramp alone
    program_all(9 * 256, 30000, 40000, 5, 0, 1);
    reg_write(REG_TARGET, 9 * 256);
    repeat (6) push_pair(rand_sample(), rand_sample());

    // Random phases with changing idle patterns
    for (int ph = 0; ph < 8; ph++) begin
      program_all(rand_target(), $urandom_range(65535),
                  ($urandom_range(7) == 0) ? $urandom_range(131071) : $urandom_range(65536),
                  ($urandom_range(9) == 0) ? 65535 :
                  (($urandom_range(3) == 0) ? 0 : $urandom_range(300)),
                  $urandom_range(7) == 0, $urandom_range(1));
      idle_mode = ph % 4;
      if (ph == 2) hold_req++;  // long receiver hold while the sender keeps going
      n = 220;
      for (int k = 0; k < n; k++) begin
        push_pair(rand_sample(), rand_sample());
        if (ph == 5 && k == n / 2) wait_drained();  // sender pause mid phase
      end
      // Retarget mid-phase so ramps run through live audio
      if (ph % 2 == 1) begin
        wait_drained();
        reg_write(REG_TARGET, rand_target());
        repeat (40) push_pair(rand_sample(), rand_sample());
      end
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
